// ===== rtl/hse_pkg.sv =====
package hse_pkg;

    // Default number of entries in the sort store.
    localparam int unsigned CAPACITY_DEF = 64;

    // Width of one stored value.
    localparam int unsigned VALUE_W = 32;

    // Sequencer states of the sort engine.
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_BLD_RD,
        S_LOADV,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_SD_RD,
        S_SD_SWAP,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/heap_sort_engine_unit.sv =====
// Channel   Direction  Handshake                Payload
// input     in         start / busy             i_value, i_last
// result    out        o_strobe (one cycle)     o_sorted_value, o_final_res, o_dropped
//
// Loading takes one item per cycle while busy is low.
// The item marked last starts the heap sort: every sift level reads both children,
// then compares and writes, and each sift-down also passes through its set-up states
// (S_BLD_RD and S_LOADV while building, S_SD_RD and S_SD_SWAP while sorting down).
// Results leave one per cycle. Reset clears the count, the overflow flag and the
// sequencer; the store keeps stale data. The receiver cannot stall: each result is
// shown for one cycle.
module heap_sort_engine_unit #(
    parameter int unsigned CAPACITY = hse_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hse_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_last,
    output logic                                o_strobe,
    output logic signed [hse_pkg::VALUE_W-1:0]  o_sorted_value,
    output logic                                o_final_res,
    output logic                                o_dropped
);
    import hse_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_ovf, n_ovf;
    logic [CW-1:0]             r_i, n_i;
    logic [AW-1:0]             r_p, n_p;
    logic [AW-1:0]             r_last, n_last;
    logic signed [VALUE_W-1:0] r_v, n_v;
    logic                      r_sortdn, n_sortdn;
    logic [AW-1:0]             r_k, n_k;
    logic                      r_emit_vld, n_emit_vld;
    logic                      r_emit_fin, n_emit_fin;
    logic                      r_emit_drop, n_emit_drop;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic                      w_re;
    logic [AW-1:0]             w_raddr0;
    logic [AW-1:0]             w_raddr1;
    logic signed [VALUE_W-1:0] w_rd0;
    logic signed [VALUE_W-1:0] w_rd1;

    logic [IW-1:0]             w_child;
    logic [IW-1:0]             w_child1;
    logic                      w_has_child;
    logic                      w_pick_right;
    logic [IW-1:0]             w_sel;
    logic signed [VALUE_W-1:0] w_selv;
    logic                      w_stop;
    logic                      w_sift_end;

    // Sort store.
    hse_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_re),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rd0),
        .o_rdata1 (w_rd1)
    );

    // Children of the current hole and the larger of the two.
    assign w_child      = {1'b0, r_p, 1'b1};
    assign w_child1     = w_child + IW'(1);
    assign w_has_child  = (w_child <= IW'(r_last));
    assign w_pick_right = (w_child1 <= IW'(r_last)) && (w_rd0 < w_rd1);
    assign w_sel        = w_pick_right ? w_child1 : w_child;
    assign w_selv       = w_pick_right ? w_rd1 : w_rd0;
    assign w_stop       = (w_selv < r_v);
    assign w_sift_end   = ((r_state == S_SIFT_RD) && !w_has_child) ||
                          ((r_state == S_SIFT_CMP) && w_stop);

    assign busy = (r_state != S_IDLE);

    // Next state and sequencer registers.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_p         = r_p;
        n_last      = r_last;
        n_v         = r_v;
        n_sortdn    = r_sortdn;
        n_k         = r_k;
        n_emit_vld  = 1'b0;
        n_emit_fin  = 1'b0;
        n_emit_drop = r_emit_drop;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_count < CW'(CAPACITY)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_k      = '0;
                n_sortdn = 1'b0;
                n_i      = r_count >> 1;
                n_last   = AW'(r_count - CW'(1));
                if (r_count == '0) begin
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else if (r_count == CW'(1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_BLD_RD;
                end
            end
            S_BLD_RD: begin
                n_p     = AW'(r_i - CW'(1));
                n_state = S_LOADV;
            end
            S_LOADV: begin
                n_v     = w_rd0;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                if (w_has_child) begin
                    n_state = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP: begin
                if (!w_stop) begin
                    n_p     = AW'(w_sel);
                    n_state = S_SIFT_RD;
                end
            end
            S_SD_RD: begin
                n_state = S_SD_SWAP;
            end
            S_SD_SWAP: begin
                n_v     = w_rd1;
                n_p     = '0;
                n_last  = AW'(r_i - CW'(1));
                n_state = S_SIFT_RD;
            end
            S_EMIT: begin
                n_emit_vld  = 1'b1;
                n_emit_drop = r_ovf;
                if ((CW'(r_k) + CW'(1)) == r_count) begin
                    n_emit_fin = 1'b1;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // After a sift-down: next build step, first sort-down step or output.
        if (w_sift_end) begin
            if (r_i > CW'(1)) begin
                n_i     = r_i - CW'(1);
                n_state = r_sortdn ? S_SD_RD : S_BLD_RD;
            end else if (!r_sortdn) begin
                n_sortdn = 1'b1;
                n_i      = r_count - CW'(1);
                n_state  = S_SD_RD;
            end else begin
                n_k     = '0;
                n_state = S_EMIT;
            end
        end
    end

    // Store accesses for each state.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_p;
        w_wdata  = r_v;
        w_re     = 1'b0;
        w_raddr0 = '0;
        w_raddr1 = '0;
        case (r_state)
            S_IDLE: begin
                w_we    = start && (r_count < CW'(CAPACITY));
                w_waddr = AW'(r_count);
                w_wdata = i_value;
            end
            S_BLD_RD: begin
                w_re     = 1'b1;
                w_raddr0 = AW'(r_i - CW'(1));
            end
            S_SIFT_RD: begin
                w_we     = !w_has_child;
                w_re     = w_has_child;
                w_raddr0 = AW'(w_child);
                w_raddr1 = AW'(w_child1);
            end
            S_SIFT_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_stop ? r_v : w_selv;
            end
            S_SD_RD: begin
                w_re     = 1'b1;
                w_raddr1 = AW'(r_i);
            end
            S_SD_SWAP: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_i);
                w_wdata = w_rd0;
            end
            S_EMIT: begin
                w_re     = 1'b1;
                w_raddr0 = r_k;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_emit_vld <= 1'b0;
            r_emit_fin <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_emit_vld <= n_emit_vld;
            r_emit_fin <= n_emit_fin;
        end
    end

    // Working registers of the sort.
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_p         <= n_p;
        r_last      <= n_last;
        r_v         <= n_v;
        r_sortdn    <= n_sortdn;
        r_k         <= n_k;
        r_emit_drop <= n_emit_drop;
    end

    // Results come straight from the store's read register.
    assign o_strobe       = r_emit_vld;
    assign o_sorted_value = w_rd0;
    assign o_final_res    = r_emit_fin;
    assign o_dropped      = r_emit_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_final_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_final_res |-> o_strobe)
        else $error("final flag without a result");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_res) |=> !o_strobe)
        else $error("result after the final one");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last && (r_count < CW'(CAPACITY)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("stored item not counted");

    a_hole_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIFT_CMP) |-> (r_p <= r_last))
        else $error("sift position outside the heap");
`endif

endmodule

// ===== rtl/hse_ram.sv =====
module hse_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [hse_pkg::VALUE_W-1:0]  i_wdata,
    input  logic                                i_re,
    input  logic [AW-1:0]                       i_raddr0,
    input  logic [AW-1:0]                       i_raddr1,
    output logic signed [hse_pkg::VALUE_W-1:0]  o_rdata0,
    output logic signed [hse_pkg::VALUE_W-1:0]  o_rdata1
);
    import hse_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule
